[rtl/bqc_pkg.sv]
// Shared types, constants and arithmetic helpers for the cascaded biquad core.
// Depends on nothing; every other file refers to it by scoped names.
package bqc_pkg;

    localparam int MAX_SECTIONS_DEF  = 8;
    localparam int COEFS_PER_SECTION = 5;
    localparam int SAMPLE_W          = 16;
    localparam int ACC_W             = 32;
    localparam int COEF_IDX_W        = 6;
    localparam int SECT_W            = 4;
    localparam int SECTIONS_RESET    = 1;
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;
    localparam int IN_SHIFT          = 12;
    localparam int W0_SHIFT          = 15;
    localparam int OUT_SHIFT         = 12;

    typedef enum logic
    {
        CMD_FILTER = 1'b0,
        CMD_COEF   = 1'b1
    } command_t;

    // Register index, taken from paddr[2].
    typedef enum logic
    {
        REG_SECTIONS = 1'b0
    } reg_index_t;

    // Coefficient positions within one section.
    typedef enum logic [2:0]
    {
        POS_A1 = 3'd0,
        POS_A2 = 3'd1,
        POS_B2 = 3'd2,
        POS_B0 = 3'd3,
        POS_B1 = 3'd4
    } coef_pos_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_A1,
        ST_A2,
        ST_B2,
        ST_B0,
        ST_B1,
        ST_FIN
    } cell_state_t;

    typedef struct packed
    {
        logic                    valid;
        logic signed [ACC_W-1:0] acc;
    } token_t;

    typedef struct packed
    {
        logic                         we;
        logic [COEF_IDX_W-1:0]        index;
        logic signed [SAMPLE_W-1:0]   value;
    } coef_wr_t;

    // Fractional product sat32(2*p*q); only -1 * -1 overflows.
    function automatic logic signed [ACC_W-1:0] frac_mul(
        input logic signed [SAMPLE_W-1:0] p,
        input logic signed [SAMPLE_W-1:0] q
    );
        logic signed [ACC_W-1:0] prod;
        prod = p * q;
        if (p == 16'sh8000 && q == 16'sh8000)
        begin
            return 32'sh7FFF_FFFF;
        end
        return {prod[ACC_W-2:0], 1'b0};
    endfunction

    // Saturating 32-bit add or subtract.
    function automatic logic signed [ACC_W-1:0] sat_addsub(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b,
        input logic                    sub
    );
        logic signed [ACC_W:0] s;
        if (sub)
        begin
            s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
        end
        else
        begin
            s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        end
        if (s[ACC_W] != s[ACC_W-1])
        begin
            return s[ACC_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

[rtl/bqc_item_if.sv]
// Input channel of the biquad core: filter samples and coefficient writes.
// Depends on bqc_pkg for field widths.
interface bqc_item_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic signed [bqc_pkg::SAMPLE_W-1:0]  sample_in;
    logic [bqc_pkg::COEF_IDX_W-1:0]       coef_index;
    logic signed [bqc_pkg::SAMPLE_W-1:0]  coef_value;
    logic                                 last_in_block;

    modport source (output valid, command, sample_in, coef_index, coef_value, last_in_block,
                    input ready);
    modport sink   (input valid, command, sample_in, coef_index, coef_value, last_in_block,
                    output ready);
endinterface

[rtl/bqc_result_if.sv]
// Output channel of the biquad core: one filtered sample per filter transaction.
// Depends on bqc_pkg for field widths.
interface bqc_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bqc_pkg::SAMPLE_W-1:0]  sample_out;
    logic                                 last_out;

    modport source (output valid, sample_out, last_out, input ready);
    modport sink   (input valid, sample_out, last_out, output ready);
endinterface

[rtl/bqc_cell.sv]
// One second-order section: five coefficients, two delay words and a multiplier
// that works through the section's products in turn. Depends on bqc_pkg.
module bqc_cell #(
    parameter int CELL_BASE = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              active,
    input  bqc_pkg::coef_wr_t coef_wr,
    input  bqc_pkg::token_t   tok_in,
    output bqc_pkg::token_t   tok_out
);

    localparam int IDX_W = 9;

    bqc_pkg::cell_state_t state_reg, state_next;

    logic signed [bqc_pkg::SAMPLE_W-1:0] coef_reg [bqc_pkg::COEFS_PER_SECTION];
    logic signed [bqc_pkg::SAMPLE_W-1:0] w1_reg, w2_reg, w0_reg;
    logic signed [bqc_pkg::ACC_W-1:0]    acc_reg, prod_reg, tok_acc_reg;
    logic                                tok_valid_reg;

    logic signed [bqc_pkg::SAMPLE_W-1:0] mul_p, mul_q;
    logic                                sum_sub;
    logic signed [bqc_pkg::ACC_W-1:0]    prod_next, sum;

    logic [IDX_W-1:0] idx_ext, idx_diff;
    logic             coef_hit;

    // Slot decode: this cell owns slots CELL_BASE to CELL_BASE + 4.
    assign idx_ext  = {{(IDX_W-bqc_pkg::COEF_IDX_W){1'b0}}, coef_wr.index};
    assign idx_diff = idx_ext - IDX_W'(CELL_BASE);
    assign coef_hit = coef_wr.we && (idx_ext >= IDX_W'(CELL_BASE))
                      && (idx_diff < IDX_W'(bqc_pkg::COEFS_PER_SECTION));

    always_ff @(posedge clk)
    begin
        if (coef_hit)
        begin
            coef_reg[idx_diff[2:0]] <= coef_wr.value;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bqc_pkg::ST_IDLE:
            begin
                if (tok_in.valid && active)
                begin
                    state_next = bqc_pkg::ST_A1;
                end
            end
            bqc_pkg::ST_A1:  state_next = bqc_pkg::ST_A2;
            bqc_pkg::ST_A2:  state_next = bqc_pkg::ST_B2;
            bqc_pkg::ST_B2:  state_next = bqc_pkg::ST_B0;
            bqc_pkg::ST_B0:  state_next = bqc_pkg::ST_B1;
            bqc_pkg::ST_B1:  state_next = bqc_pkg::ST_FIN;
            bqc_pkg::ST_FIN: state_next = bqc_pkg::ST_IDLE;
            default:         state_next = bqc_pkg::ST_IDLE;
        endcase
    end

    // Operand selection: states A1 to B1 each start one product, and the state after each folds it in.
    always_comb
    begin
        mul_p   = w1_reg;
        mul_q   = coef_reg[bqc_pkg::POS_A1];
        sum_sub = 1'b0;
        case (state_reg)
            bqc_pkg::ST_A1:
            begin
                mul_p = w1_reg;
                mul_q = coef_reg[bqc_pkg::POS_A1];
            end
            bqc_pkg::ST_A2:
            begin
                mul_p   = w2_reg;
                mul_q   = coef_reg[bqc_pkg::POS_A2];
                sum_sub = 1'b1;
            end
            bqc_pkg::ST_B2:
            begin
                mul_p   = w2_reg;
                mul_q   = coef_reg[bqc_pkg::POS_B2];
                sum_sub = 1'b1;
            end
            bqc_pkg::ST_B0:
            begin
                mul_p = acc_reg[bqc_pkg::W0_SHIFT+bqc_pkg::SAMPLE_W-1:bqc_pkg::W0_SHIFT];
                mul_q = coef_reg[bqc_pkg::POS_B0];
            end
            bqc_pkg::ST_B1:
            begin
                mul_p = w1_reg;
                mul_q = coef_reg[bqc_pkg::POS_B1];
            end
            default:
            begin
                mul_p   = w1_reg;
                mul_q   = coef_reg[bqc_pkg::POS_A1];
                sum_sub = 1'b0;
            end
        endcase
    end

    assign prod_next = bqc_pkg::frac_mul(mul_p, mul_q);
    assign sum       = bqc_pkg::sat_addsub(acc_reg, prod_reg, sum_sub);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bqc_pkg::ST_IDLE;
            tok_valid_reg <= 1'b0;
            w1_reg        <= '0;
            w2_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                bqc_pkg::ST_IDLE:
                begin
                    // A section beyond the count in use passes the token on untouched.
                    tok_valid_reg <= tok_in.valid && !active;
                end
                bqc_pkg::ST_FIN:
                begin
                    tok_valid_reg <= 1'b1;
                    w2_reg        <= w1_reg;
                    w1_reg        <= w0_reg;
                end
                default:
                begin
                    tok_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (state_reg)
            bqc_pkg::ST_IDLE:
            begin
                acc_reg     <= tok_in.acc;
                tok_acc_reg <= tok_in.acc;
            end
            bqc_pkg::ST_A2, bqc_pkg::ST_B2, bqc_pkg::ST_B1:
            begin
                acc_reg <= sum;
            end
            bqc_pkg::ST_B0:
            begin
                w0_reg  <= acc_reg[bqc_pkg::W0_SHIFT+bqc_pkg::SAMPLE_W-1:bqc_pkg::W0_SHIFT];
                acc_reg <= prod_reg;
            end
            bqc_pkg::ST_FIN:
            begin
                tok_acc_reg <= sum;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign tok_out.valid = tok_valid_reg;
    assign tok_out.acc   = tok_acc_reg;

endmodule

[rtl/biquad_cascade_iir_q15_core.sv]
// Top level of the cascaded direct form II biquad core on Q15 samples.
// Depends on bqc_pkg, bqc_item_if, bqc_result_if and bqc_cell.
//
// A coefficient write gives no result. A filter transaction travels down a
// row of MAX_SECTIONS section cells; each cell in use works its five
// fractional products through its own multiplier, one per cycle, while a
// cell beyond sections_in_use passes the accumulator on through its token
// register. The next transaction is taken in the cycle its predecessor
// reaches the output register. One sample is in the cells at a time; the
// output register and a one-entry holding register let the next sample
// start while a result still waits to be taken. The section count is
// written through the APB port at address 0; the user must write it only
// while the core is idle, as the core itself does not enforce this.
module biquad_cascade_iir_q15_core #(
    parameter int MAX_SECTIONS = bqc_pkg::MAX_SECTIONS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bqc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bqc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bqc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    bqc_item_if.sink                          item,
    bqc_result_if.source                      result
);

    localparam int CNT_W = 6;

    logic [bqc_pkg::SECT_W-1:0] sections_reg;
    logic                       busy_reg, busy_next;
    logic                       last_reg;
    logic                       pend_valid_reg;
    logic signed [bqc_pkg::SAMPLE_W-1:0] pend_sample_reg;
    logic                       pend_last_reg;
    logic                       out_valid_reg;
    logic signed [bqc_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic                       out_last_reg;

    logic                       accept, accept_filter, done, out_free, cfg_write;
    logic signed [bqc_pkg::SAMPLE_W-1:0] chain_sample;
    logic [MAX_SECTIONS-1:0]    cell_active;
    logic [MAX_SECTIONS:0]      tok_valid_vec;

    bqc_pkg::token_t   tok [MAX_SECTIONS+1];
    bqc_pkg::coef_wr_t coef_wr;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == bqc_pkg::REG_SECTIONS);
    assign prdata    = (paddr[2] == bqc_pkg::REG_SECTIONS)
                       ? {{(bqc_pkg::APB_DATA_W-bqc_pkg::SECT_W){1'b0}}, sections_reg}
                       : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sections_reg <= bqc_pkg::SECT_W'(bqc_pkg::SECTIONS_RESET);
        end
        else if (cfg_write)
        begin
            sections_reg <= pwdata[bqc_pkg::SECT_W-1:0];
        end
    end

    // Input side.
    assign item.ready    = !busy_reg;
    assign accept        = item.valid && item.ready;
    assign accept_filter = accept && (item.command == bqc_pkg::CMD_FILTER);

    assign coef_wr.we    = accept && (item.command == bqc_pkg::CMD_COEF);
    assign coef_wr.index = item.coef_index;
    assign coef_wr.value = item.coef_value;

    assign tok[0].valid = accept_filter;
    assign tok[0].acc   = {{(bqc_pkg::ACC_W-bqc_pkg::SAMPLE_W-bqc_pkg::IN_SHIFT)
                            {item.sample_in[bqc_pkg::SAMPLE_W-1]}},
                           item.sample_in, {bqc_pkg::IN_SHIFT{1'b0}}};

    // Section 0 always runs, so a count of zero acts as one; counts above the
    // row length simply enable every cell.
    genvar k;
    generate
        for (k = 0; k < MAX_SECTIONS; k++)
        begin : g_cell
            assign cell_active[k] = (k == 0)
                || ({{(CNT_W-bqc_pkg::SECT_W){1'b0}}, sections_reg} > CNT_W'(k));

            bqc_cell #(
                .CELL_BASE (bqc_pkg::COEFS_PER_SECTION * k)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .active  (cell_active[k]),
                .coef_wr (coef_wr),
                .tok_in  (tok[k]),
                .tok_out (tok[k+1])
            );
        end
        for (k = 0; k <= MAX_SECTIONS; k++)
        begin : g_vvec
            assign tok_valid_vec[k] = tok[k].valid;
        end
    endgenerate

    assign done         = tok[MAX_SECTIONS].valid;
    assign chain_sample = tok[MAX_SECTIONS].acc[bqc_pkg::OUT_SHIFT+bqc_pkg::SAMPLE_W-1:
                                                 bqc_pkg::OUT_SHIFT];
    assign out_free     = !out_valid_reg || result.ready;

    // Busy clears once the finished sample sits in the output register.
    always_comb
    begin
        busy_next = busy_reg;
        if (accept_filter)
        begin
            busy_next = 1'b1;
        end
        else if ((done || pend_valid_reg) && out_free)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (out_free)
            begin
                out_valid_reg  <= done || pend_valid_reg;
                pend_valid_reg <= 1'b0;
            end
            else if (done)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_filter)
        begin
            last_reg <= item.last_in_block;
        end
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_sample_reg <= pend_sample_reg;
                out_last_reg   <= pend_last_reg;
            end
            else
            begin
                out_sample_reg <= chain_sample;
                out_last_reg   <= last_reg;
            end
        end
        else if (done)
        begin
            pend_sample_reg <= chain_sample;
            pend_last_reg   <= last_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.sample_out = out_sample_reg;
    assign result.last_out   = out_last_reg;

    // Only one sample may be moving through the row of cells.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valid_vec))
        else $error("more than one sample in the section row");

    a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> busy_reg)
        else $error("held result while the core is not busy");

    a_done_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (busy_reg && !pend_valid_reg))
        else $error("section row finished with no sample in flight");

    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> $past(done || pend_valid_reg))
        else $error("busy cleared without a result reaching the output register");

endmodule
